/* hw/rtl/cdsm_pkg.sv */
`default_nettype none

package cdsm_pkg;

    localparam int COORD_WIDTH = 32;

    typedef logic [COORD_WIDTH-1:0] t_coord;

    // action codes
    localparam logic [1:0] ACT_HEADER = 2'd0;
    localparam logic [1:0] ACT_BLOCK  = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    // target strand codes
    localparam logic [1:0] TS_ABSENT = 2'd0;
    localparam logic [1:0] TS_PLUS   = 2'd1;
    localparam logic [1:0] TS_MINUS  = 2'd2;

    // decoded item held in the input register
    typedef struct packed {
        logic   is_header;
        logic   is_block;
        logic   is_finish;
        t_coord rna_start;
        t_coord rna_end;
        logic   start_flag;
        logic   end_flag;
        logic   gene_minus;
        logic   target_minus;
        t_coord target_length;
        t_coord query_start;
        t_coord target_start;
        t_coord block_length;
        t_coord tq_diff;
        t_coord block_end;
    } t_item;

    typedef struct packed {
        t_coord genome_start;
        t_coord genome_end;
        logic   start_complete;
        logic   end_complete;
        logic   no_blocks_error;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/cdsm_in_if.sv */
`default_nettype none

interface cdsm_in_if import cdsm_pkg::*;;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    t_coord     cds_start;
    t_coord     cds_end;
    logic       start_complete;
    logic       end_complete;
    logic       query_minus;
    logic [1:0] target_strand;
    t_coord     query_size;
    t_coord     target_size;
    t_coord     block_query_start;
    t_coord     block_target_start;
    t_coord     block_length;

    modport source (
        output valid, action, cds_start, cds_end, start_complete, end_complete,
               query_minus, target_strand, query_size, target_size,
               block_query_start, block_target_start, block_length,
        input  ready
    );

    modport sink (
        input  valid, action, cds_start, cds_end, start_complete, end_complete,
               query_minus, target_strand, query_size, target_size,
               block_query_start, block_target_start, block_length,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/cdsm_out_if.sv */
`default_nettype none

interface cdsm_out_if import cdsm_pkg::*;;
    logic   valid;
    logic   ready;
    t_coord genome_start;
    t_coord genome_end;
    logic   start_complete_out;
    logic   end_complete_out;
    logic   no_blocks_error;

    modport source (
        output valid, genome_start, genome_end, start_complete_out, end_complete_out,
               no_blocks_error,
        input  ready
    );

    modport sink (
        input  valid, genome_start, genome_end, start_complete_out, end_complete_out,
               no_blocks_error,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/cdsm_in_stage.sv */
`default_nettype none

module cdsm_in_stage import cdsm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdsm_in_if.sink    i_item,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  target_minus;

    assign i_item.ready = !r_valid || i_ready;

    // decode the transaction and do the work that needs no running state
    always_comb begin
        target_minus        = (i_item.target_strand == TS_MINUS);
        n_item              = '0;
        n_item.is_header    = (i_item.action == ACT_HEADER);
        n_item.is_block     = (i_item.action == ACT_BLOCK);
        n_item.is_finish    = (i_item.action == ACT_FINISH);
        if (i_item.query_minus) begin
            n_item.rna_start  = i_item.query_size - i_item.cds_end;
            n_item.rna_end    = i_item.query_size - i_item.cds_start;
            n_item.start_flag = i_item.end_complete;
            n_item.end_flag   = i_item.start_complete;
        end else begin
            n_item.rna_start  = i_item.cds_start;
            n_item.rna_end    = i_item.cds_end;
            n_item.start_flag = i_item.start_complete;
            n_item.end_flag   = i_item.end_complete;
        end
        n_item.target_minus = target_minus;
        n_item.gene_minus   = (i_item.target_strand == TS_ABSENT) ? i_item.query_minus
                                                                  : (i_item.query_minus != target_minus);
        n_item.target_length = i_item.target_size;
        n_item.query_start   = i_item.block_query_start;
        n_item.target_start  = i_item.block_target_start;
        n_item.block_length  = i_item.block_length;
        n_item.tq_diff       = i_item.block_target_start - i_item.block_query_start;
        n_item.block_end     = i_item.block_target_start + i_item.block_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* hw/rtl/cdsm_map_core.sv */
`default_nettype none

module cdsm_map_core import cdsm_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_item  i_item,
    output logic        o_ready,
    output logic        o_res_valid,
    output t_result     o_res,
    input  wire logic   i_res_ready
);

    t_coord r_rna_start, n_rna_start;
    t_coord r_rna_end, n_rna_end;
    logic   r_start_flag, n_start_flag;
    logic   r_end_flag, n_end_flag;
    logic   r_gene_minus, n_gene_minus;
    logic   r_target_minus, n_target_minus;
    t_coord r_target_length, n_target_length;
    logic   r_start_found, n_start_found;
    t_coord r_start_pos, n_start_pos;
    logic   r_end_found, n_end_found;
    t_coord r_end_pos, n_end_pos;
    t_coord r_prev_end, n_prev_end;
    logic   r_seen_block, n_seen_block;

    logic   take;
    t_coord start_diff;
    t_coord end_diff;
    t_coord gs_fwd;
    t_coord ge_fwd;
    t_coord mir_start;
    t_coord mir_end;
    t_coord mir_prev;
    logic   collapse;
    logic   sc;
    logic   ec;

    // only a finish waits for room at the output
    assign o_ready     = !i_item.is_finish || i_res_ready;
    assign take        = i_valid && o_ready;
    assign o_res_valid = i_valid && i_item.is_finish;

    assign start_diff = r_rna_start - i_item.query_start;
    assign end_diff   = r_rna_end - i_item.query_start;

    always_comb begin
        n_rna_start     = r_rna_start;
        n_rna_end       = r_rna_end;
        n_start_flag    = r_start_flag;
        n_end_flag      = r_end_flag;
        n_gene_minus    = r_gene_minus;
        n_target_minus  = r_target_minus;
        n_target_length = r_target_length;
        n_start_found   = r_start_found;
        n_start_pos     = r_start_pos;
        n_end_found     = r_end_found;
        n_end_pos       = r_end_pos;
        n_prev_end      = r_prev_end;
        n_seen_block    = r_seen_block;
        if (take && i_item.is_header) begin
            n_rna_start     = i_item.rna_start;
            n_rna_end       = i_item.rna_end;
            n_start_flag    = i_item.start_flag;
            n_end_flag      = i_item.end_flag;
            n_gene_minus    = i_item.gene_minus;
            n_target_minus  = i_item.target_minus;
            n_target_length = i_item.target_length;
            n_start_found   = 1'b0;
            n_start_pos     = '0;
            n_end_found     = 1'b0;
            n_end_pos       = '0;
            n_prev_end      = '0;
            n_seen_block    = 1'b0;
        end else if (take && i_item.is_block) begin
            if (!r_start_found) begin
                if (r_rna_start < i_item.query_start) begin
                    // start in the gap: snap to this block
                    n_start_pos   = i_item.target_start;
                    n_start_flag  = 1'b0;
                    n_start_found = 1'b1;
                end else if (start_diff < i_item.block_length) begin
                    n_start_pos   = r_rna_start + i_item.tq_diff;
                    n_start_found = 1'b1;
                end
            end
            if (!r_end_found) begin
                if (r_rna_end <= i_item.query_start) begin
                    // end in the gap: snap back to the previous block, or to this block if none came before
                    n_end_pos   = r_seen_block ? r_prev_end : i_item.target_start;
                    n_end_flag  = 1'b0;
                    n_end_found = 1'b1;
                end else if (end_diff <= i_item.block_length) begin
                    n_end_pos   = r_rna_end + i_item.tq_diff;
                    n_end_found = 1'b1;
                end
            end
            n_prev_end   = i_item.block_end;
            n_seen_block = 1'b1;
        end
    end

    // result of a finish
    assign gs_fwd    = r_start_found ? r_start_pos : r_prev_end;
    assign ge_fwd    = r_end_found ? r_end_pos : r_prev_end;
    assign collapse  = (gs_fwd >= ge_fwd);
    assign mir_start = r_target_length - r_start_pos;
    assign mir_end   = r_target_length - r_end_pos;
    assign mir_prev  = r_target_length - r_prev_end;

    always_comb begin
        sc = r_start_flag && r_start_found && !collapse;
        ec = r_end_flag && r_end_found && !collapse;
        o_res = '0;
        if (!r_seen_block) begin
            o_res.no_blocks_error = 1'b1;
        end else begin
            if (collapse) begin
                o_res.genome_start = r_target_minus ? mir_prev : r_prev_end;
                o_res.genome_end   = r_target_minus ? mir_prev : r_prev_end;
            end else if (r_target_minus) begin
                o_res.genome_start = r_end_found ? mir_end : mir_prev;
                o_res.genome_end   = r_start_found ? mir_start : mir_prev;
            end else begin
                o_res.genome_start = gs_fwd;
                o_res.genome_end   = ge_fwd;
            end
            o_res.start_complete = r_gene_minus ? ec : sc;
            o_res.end_complete   = r_gene_minus ? sc : ec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rna_start     <= '0;
            r_rna_end       <= '0;
            r_start_flag    <= 1'b0;
            r_end_flag      <= 1'b0;
            r_gene_minus    <= 1'b0;
            r_target_minus  <= 1'b0;
            r_target_length <= '0;
            r_start_found   <= 1'b0;
            r_start_pos     <= '0;
            r_end_found     <= 1'b0;
            r_end_pos       <= '0;
            r_prev_end      <= '0;
            r_seen_block    <= 1'b0;
        end else begin
            r_rna_start     <= n_rna_start;
            r_rna_end       <= n_rna_end;
            r_start_flag    <= n_start_flag;
            r_end_flag      <= n_end_flag;
            r_gene_minus    <= n_gene_minus;
            r_target_minus  <= n_target_minus;
            r_target_length <= n_target_length;
            r_start_found   <= n_start_found;
            r_start_pos     <= n_start_pos;
            r_end_found     <= n_end_found;
            r_end_pos       <= n_end_pos;
            r_prev_end      <= n_prev_end;
            r_seen_block    <= n_seen_block;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/cdsm_out_stage.sv */
`default_nettype none

module cdsm_out_stage import cdsm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_res,
    output logic         o_ready,
    cdsm_out_if.source   o_result
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= i_res;
        end
    end

    assign o_result.valid              = r_valid;
    assign o_result.genome_start       = r_res.genome_start;
    assign o_result.genome_end         = r_res.genome_end;
    assign o_result.start_complete_out = r_res.start_complete;
    assign o_result.end_complete_out   = r_res.end_complete;
    assign o_result.no_blocks_error    = r_res.no_blocks_error;

endmodule

`default_nettype wire

/* hw/rtl/cds_to_genome_coord_map.sv */
`default_nettype none

// Maps an mRNA coding range onto target plus-strand coordinates through an
// alignment streamed as a header transaction, one transaction per block in
// order, and a finish transaction that yields the single result. A new
// transaction is accepted on every clock while the output is being taken;
// the block-state update in the core (one subtract and compare per range
// end against the running state) sets that rate. A result passes from its
// accepted finish through one input register, then one output register. A
// finish with no block since the header returns zero coordinates with
// no_blocks_error set. Repeating a finish repeats the result.
module cds_to_genome_coord_map import cdsm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdsm_in_if.sink    i_item,
    cdsm_out_if.source o_result
);

    logic    core_valid;
    t_item   core_item;
    logic    core_ready;
    logic    res_valid;
    t_result res;
    logic    res_ready;

    cdsm_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (core_valid),
        .o_item  (core_item),
        .i_ready (core_ready)
    );

    cdsm_map_core u_map_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (core_valid),
        .i_item      (core_item),
        .o_ready     (core_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    cdsm_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .i_res    (res),
        .o_ready  (res_ready),
        .o_result (o_result)
    );

`ifndef ASSERT_OFF
    // a finish taken by the core shows up at the output next cycle
    a_finish_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_valid && core_ready && core_item.is_finish) |=> o_result.valid)
        else $error("finish transaction did not reach the output register");

    // the error result carries no coordinates and no completeness
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.no_blocks_error) |->
        (o_result.genome_start == '0 && o_result.genome_end == '0 &&
         !o_result.start_complete_out && !o_result.end_complete_out))
        else $error("no-blocks result carries data");

    // a stalled item in the input register holds until the core takes it
    a_core_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_valid && !core_ready) |=> (core_valid && $stable(core_item)))
        else $error("input register lost a stalled transaction");
`endif

endmodule

`default_nettype wire

/* sim/tb_cds_to_genome_coord_map.sv */
`default_nettype none

module tb_cds_to_genome_coord_map;
    import cdsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    // codes the package leaves unnamed
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] TS_ODD     = 2'd3;

    typedef struct {
        logic [1:0] action;
        t_coord     cds_start;
        t_coord     cds_end;
        logic       start_complete;
        logic       end_complete;
        logic       query_minus;
        logic [1:0] target_strand;
        t_coord     query_size;
        t_coord     target_size;
        t_coord     block_query_start;
        t_coord     block_target_start;
        t_coord     block_length;
    } t_map_item;

    logic i_clk;
    logic i_rst_n;

    cdsm_in_if  in_if ();
    cdsm_out_if out_if ();

    cds_to_genome_coord_map u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_if),
        .o_result (out_if)
    );

    // mapper state mirrored by the testbench
    t_coord rng_lo       = '0;
    t_coord rng_hi       = '0;
    t_coord tgt_len      = '0;
    t_coord lo_pos       = '0;
    t_coord hi_pos       = '0;
    t_coord last_blk_end = '0;
    logic   lo_flag      = 1'b0;
    logic   hi_flag      = 1'b0;
    logic   gene_rev     = 1'b0;
    logic   tgt_rev      = 1'b0;
    logic   lo_hit       = 1'b0;
    logic   hi_hit       = 1'b0;
    logic   any_blk      = 1'b0;

    t_result   mapped_q[$];
    t_map_item seen_item;
    t_result   got_result;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int n_sent     = 0;
    int n_records  = 0;
    int n_checked  = 0;
    int n_nob      = 0;
    int n_mismatch = 0;
    int n_fail     = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
                 mapped_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_map_item rand_item();
        t_map_item it;
        it.action             = 2'($urandom_range(3));
        it.cds_start          = rand_coord();
        it.cds_end            = rand_coord();
        it.start_complete     = 1'($urandom_range(1));
        it.end_complete       = 1'($urandom_range(1));
        it.query_minus        = 1'($urandom_range(1));
        it.target_strand      = 2'($urandom_range(3));
        it.query_size         = rand_coord();
        it.target_size        = rand_coord();
        it.block_query_start  = rand_coord();
        it.block_target_start = rand_coord();
        it.block_length       = rand_coord();
        return it;
    endfunction

    function automatic t_map_item hdr(t_coord s, t_coord e, logic sc, logic ec, logic qm,
                                      logic [1:0] ts, t_coord qsz, t_coord tsz);
        t_map_item it;
        it                = rand_item();
        it.action         = ACT_HEADER;
        it.cds_start      = s;
        it.cds_end        = e;
        it.start_complete = sc;
        it.end_complete   = ec;
        it.query_minus    = qm;
        it.target_strand  = ts;
        it.query_size     = qsz;
        it.target_size    = tsz;
        return it;
    endfunction

    function automatic t_map_item blk(t_coord qs, t_coord ts, t_coord len);
        t_map_item it;
        it                    = rand_item();
        it.action             = ACT_BLOCK;
        it.block_query_start  = qs;
        it.block_target_start = ts;
        it.block_length       = len;
        return it;
    endfunction

    function automatic t_map_item fin();
        t_map_item it;
        it        = rand_item();
        it.action = ACT_FINISH;
        return it;
    endfunction

    // Advance the mirrored mapper by one accepted transaction.
    task automatic map_predict(input t_map_item it);
        t_coord  bend;
        t_coord  off;
        t_coord  gs;
        t_coord  ge;
        t_coord  tmp_c;
        logic    sc;
        logic    ec;
        logic    tmp_f;
        t_result r;
        case (it.action)
            ACT_HEADER: begin
                if (it.query_minus) begin
                    rng_lo  = it.query_size - it.cds_end;
                    rng_hi  = it.query_size - it.cds_start;
                    lo_flag = it.end_complete;
                    hi_flag = it.start_complete;
                end else begin
                    rng_lo  = it.cds_start;
                    rng_hi  = it.cds_end;
                    lo_flag = it.start_complete;
                    hi_flag = it.end_complete;
                end
                tgt_rev  = (it.target_strand == TS_MINUS);
                gene_rev = (it.target_strand == TS_ABSENT) ? it.query_minus
                                                           : (it.query_minus != tgt_rev);
                tgt_len      = it.target_size;
                lo_hit       = 1'b0;
                hi_hit       = 1'b0;
                any_blk      = 1'b0;
                lo_pos       = '0;
                hi_pos       = '0;
                last_blk_end = '0;
            end
            ACT_BLOCK: begin
                bend = it.block_target_start + it.block_length;
                if (!lo_hit) begin
                    off = rng_lo - it.block_query_start;
                    if (rng_lo < it.block_query_start) begin
                        lo_pos  = it.block_target_start;
                        lo_flag = 1'b0;
                        lo_hit  = 1'b1;
                    end else if (off < it.block_length) begin
                        lo_pos = it.block_target_start + off;
                        lo_hit = 1'b1;
                    end
                end
                if (!hi_hit) begin
                    off = rng_hi - it.block_query_start;
                    if (rng_hi <= it.block_query_start) begin
                        // end in a gap: previous block's end, or this block's start
                        hi_pos  = any_blk ? last_blk_end : it.block_target_start;
                        hi_flag = 1'b0;
                        hi_hit  = 1'b1;
                    end else if (off <= it.block_length) begin
                        hi_pos = it.block_target_start + off;
                        hi_hit = 1'b1;
                    end
                end
                last_blk_end = bend;
                any_blk      = 1'b1;
            end
            ACT_FINISH: begin
                if (!any_blk) begin
                    r.genome_start    = '0;
                    r.genome_end      = '0;
                    r.start_complete  = 1'b0;
                    r.end_complete    = 1'b0;
                    r.no_blocks_error = 1'b1;
                end else begin
                    gs = lo_pos;
                    ge = hi_pos;
                    sc = lo_flag;
                    ec = hi_flag;
                    if (!lo_hit) begin
                        gs = last_blk_end;
                        sc = 1'b0;
                    end
                    if (!hi_hit) begin
                        ge = last_blk_end;
                        ec = 1'b0;
                    end
                    if (gs >= ge) begin
                        gs = last_blk_end;
                        ge = last_blk_end;
                        sc = 1'b0;
                        ec = 1'b0;
                    end
                    if (gene_rev) begin
                        tmp_f = sc;
                        sc    = ec;
                        ec    = tmp_f;
                    end
                    if (tgt_rev) begin
                        tmp_c = tgt_len - ge;
                        ge    = tgt_len - gs;
                        gs    = tmp_c;
                    end
                    r.genome_start    = gs;
                    r.genome_end      = ge;
                    r.start_complete  = sc;
                    r.end_complete    = ec;
                    r.no_blocks_error = 1'b0;
                end
                mapped_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (mapped_q.size() == 0) begin
            n_fail++;
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
                $display("Unexpected result: start %h end %h flags %0b%0b err %0b",
                         got.genome_start, got.genome_end, got.start_complete,
                         got.end_complete, got.no_blocks_error);
        end else begin
            want = mapped_q.pop_front();
            n_checked++;
            if (want.no_blocks_error)
                n_nob++;
            if (got.genome_start !== want.genome_start || got.genome_end !== want.genome_end ||
                got.start_complete !== want.start_complete ||
                got.end_complete !== want.end_complete ||
                got.no_blocks_error !== want.no_blocks_error) begin
                n_fail++;
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display({"Mismatch on result %0d: expected %h..%h flags %0b%0b err %0b,",
                              " got %h..%h flags %0b%0b err %0b"},
                             n_checked, want.genome_start, want.genome_end,
                             want.start_complete, want.end_complete, want.no_blocks_error,
                             got.genome_start, got.genome_end, got.start_complete,
                             got.end_complete, got.no_blocks_error);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            seen_item.action             = in_if.action;
            seen_item.cds_start          = in_if.cds_start;
            seen_item.cds_end            = in_if.cds_end;
            seen_item.start_complete     = in_if.start_complete;
            seen_item.end_complete       = in_if.end_complete;
            seen_item.query_minus        = in_if.query_minus;
            seen_item.target_strand      = in_if.target_strand;
            seen_item.query_size         = in_if.query_size;
            seen_item.target_size        = in_if.target_size;
            seen_item.block_query_start  = in_if.block_query_start;
            seen_item.block_target_start = in_if.block_target_start;
            seen_item.block_length       = in_if.block_length;
            map_predict(seen_item);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got_result.genome_start    = out_if.genome_start;
            got_result.genome_end      = out_if.genome_end;
            got_result.start_complete  = out_if.start_complete_out;
            got_result.end_complete    = out_if.end_complete_out;
            got_result.no_blocks_error = out_if.no_blocks_error;
            check_result(got_result);
        end
    end

    always @(posedge i_clk)
        out_if.ready <= ($urandom_range(99) >= stall_pct);

    // Present one transaction and hold it until the mapper takes it.
    task automatic send_item(input t_map_item it);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid              <= 1'b1;
        in_if.action             <= it.action;
        in_if.cds_start          <= it.cds_start;
        in_if.cds_end            <= it.cds_end;
        in_if.start_complete     <= it.start_complete;
        in_if.end_complete       <= it.end_complete;
        in_if.query_minus        <= it.query_minus;
        in_if.target_strand      <= it.target_strand;
        in_if.query_size         <= it.query_size;
        in_if.target_size        <= it.target_size;
        in_if.block_query_start  <= it.block_query_start;
        in_if.block_target_start <= it.block_target_start;
        in_if.block_length       <= it.block_length;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        if (it.action != ACT_UNUSED)
            n_sent++;
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (mapped_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Header, ordered blocks and finish with random but plausible coordinates.
    task automatic send_record();
        t_coord    bq[6];
        t_coord    bt[6];
        t_coord    bl[6];
        t_coord    q;
        t_coord    t;
        t_coord    span;
        t_coord    tmp;
        int        nblk;
        t_map_item it;
        nblk = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 6);
        q    = $urandom_range(40);
        t    = ($urandom_range(3) == 0) ? $urandom : $urandom_range(100000);
        for (int i = 0; i < nblk; i++) begin
            bl[i] = ($urandom_range(15) == 0) ? 32'd0 : $urandom_range(1, 300);
            bq[i] = q;
            bt[i] = t;
            q     = q + bl[i] + ($urandom_range(1) ? 0 : $urandom_range(1, 60));
            t     = t + bl[i] + $urandom_range(2000);
        end
        span         = q + 40;
        it           = rand_item();
        it.action    = ACT_HEADER;
        it.cds_start = $urandom_range(span);
        it.cds_end   = $urandom_range(span);
        if (it.cds_start > it.cds_end && $urandom_range(7) != 0) begin
            tmp          = it.cds_start;
            it.cds_start = it.cds_end;
            it.cds_end   = tmp;
        end
        if ($urandom_range(7) != 0)
            it.query_size = span + $urandom_range(50);
        if ($urandom_range(7) != 0)
            it.target_size = t + $urandom_range(1000);
        send_item(it);
        for (int i = 0; i < nblk; i++)
            send_item(blk(bq[i], bt[i], bl[i]));
        send_item(fin());
        if ($urandom_range(9) == 0)
            send_item(fin());
        n_records++;
    endtask

    task automatic test_no_blocks();
        send_item(fin());
        // block straight after reset works on the zero header
        send_item(blk(32'd0, 32'd100, 32'd10));
        send_item(fin());
        send_item(hdr(32'd10, 32'd20, 1'b1, 1'b1, 1'b0, TS_PLUS, 32'd100, 32'd1000));
        send_item(fin());
    endtask

    task automatic test_gap_snap();
        send_item(hdr(32'd5, 32'd150, 1'b1, 1'b1, 1'b0, TS_PLUS, 32'd200, 32'd10000));
        send_item(blk(32'd10, 32'd1000, 32'd50));
        send_item(blk(32'd100, 32'd3000, 32'd30));
        send_item(blk(32'd200, 32'd5000, 32'd20));
        send_item(fin());
        // end before the first block snaps to its start, then finish again
        send_item(hdr(32'd0, 32'd5, 1'b1, 1'b1, 1'b0, TS_ABSENT, 32'd100, 32'd100));
        send_item(blk(32'd10, 32'd500, 32'd20));
        send_item(fin());
        send_item(fin());
    endtask

    task automatic test_strands();
        send_item(hdr(32'd10, 32'd40, 1'b1, 1'b0, 1'b1, TS_MINUS, 32'd100, 32'd2000));
        send_item(blk(32'd50, 32'd300, 32'd60));
        send_item(fin());
        send_item(hdr('1, '0, 1'b1, 1'b1, 1'b1, TS_ABSENT, '1, '1));
        send_item(blk('1, '1, '1));
        send_item(fin());
        // odd strand code behaves as plus; target wraps past the top
        send_item(hdr('0, '1, 1'b1, 1'b1, 1'b0, TS_ODD, '0, '0));
        send_item(blk('0, 32'hFFFF_FF00, 32'h200));
        send_item(fin());
    endtask

    task automatic test_unfound();
        send_item(hdr(32'd500, 32'd600, 1'b1, 1'b1, 1'b0, TS_PLUS, 32'd1000, 32'd1000));
        send_item(blk(32'd0, 32'd0, 32'd100));
        send_item(blk(32'd200, 32'd300, 32'd100));
        send_item(fin());
        send_item(hdr(32'd50, 32'd900, 1'b1, 1'b1, 1'b0, TS_PLUS, 32'd1000, 32'd1000));
        send_item(blk(32'd0, 32'd0, 32'd100));
        send_item(blk(32'd150, 32'd400, 32'd0));
        send_item(fin());
    endtask

    task automatic test_ignored_action();
        t_map_item it;
        it        = rand_item();
        it.action = ACT_UNUSED;
        send_item(it);
        send_item(fin());
    endtask

    task automatic test_random(input int n_items, input int send_idle, input int recv_stall);
        int base;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        base      = n_sent;
        while (n_sent - base < n_items) begin
            if ($urandom_range(9) == 0)
                send_item(rand_item());
            else
                send_record();
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n                  <= 1'b0;
        in_if.valid              <= 1'b0;
        in_if.action             <= ACT_HEADER;
        in_if.cds_start          <= '0;
        in_if.cds_end            <= '0;
        in_if.start_complete     <= 1'b0;
        in_if.end_complete       <= 1'b0;
        in_if.query_minus        <= 1'b0;
        in_if.target_strand      <= TS_ABSENT;
        in_if.query_size         <= '0;
        in_if.target_size        <= '0;
        in_if.block_query_start  <= '0;
        in_if.block_target_start <= '0;
        in_if.block_length       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_no_blocks();
        test_gap_snap();
        test_strands();
        test_unfound();
        test_ignored_action();
        wait_drained();

        test_random(500, 0, 0);
        test_random(500, 78, 0);
        test_random(500, 0, 78);
        test_random(500, 10, 10);

        $display("Sent %0d transactions (%0d random alignment records), checked %0d results",
                 n_sent, n_records, n_checked);
        $display("including %0d no-block errors, across four idling phases; %0d mismatches",
                 n_nob, n_mismatch);
        if (n_fail == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/cdsm_pkg.sv
hw/rtl/cdsm_in_if.sv
hw/rtl/cdsm_out_if.sv
hw/rtl/cdsm_in_stage.sv
hw/rtl/cdsm_map_core.sv
hw/rtl/cdsm_out_stage.sv
hw/rtl/cds_to_genome_coord_map.sv
sim/tb_cds_to_genome_coord_map.sv
